// ===== rtl/pld_pkg.sv =====
// Shared types, codes and lookup tables for the pkt-line stream decoder.
// No dependencies; every other file in rtl/ imports this package.
package pld_pkg;

    localparam int LEAD_DEPTH_DEF = 10;
    localparam int MAX_OID_DEF    = 64;
    localparam int OID_MIN        = 40;
    localparam int CMD_DEPTH      = 4;
    localparam int RES_DEPTH      = 4;
    localparam int NPAT           = 12;
    localparam int PAT_MAX        = 9;

    // packet kinds
    localparam logic [3:0] K_FLUSH     = 4'd0;
    localparam logic [3:0] K_DATA      = 4'd1;
    localparam logic [3:0] K_PROGRESS  = 4'd2;
    localparam logic [3:0] K_SBERR     = 4'd3;
    localparam logic [3:0] K_ACK       = 4'd4;
    localparam logic [3:0] K_NAK       = 4'd5;
    localparam logic [3:0] K_ERR       = 4'd6;
    localparam logic [3:0] K_COMMENT   = 4'd7;
    localparam logic [3:0] K_OK        = 4'd8;
    localparam logic [3:0] K_NG        = 4'd9;
    localparam logic [3:0] K_UNPACK    = 4'd10;
    localparam logic [3:0] K_SHALLOW   = 4'd11;
    localparam logic [3:0] K_UNSHALLOW = 4'd12;
    localparam logic [3:0] K_REF       = 4'd13;

    // result parts
    localparam logic [2:0] P_EVENT  = 3'd0;
    localparam logic [2:0] P_OID    = 3'd1;
    localparam logic [2:0] P_NAME   = 3'd2;
    localparam logic [2:0] P_CAPS   = 3'd3;
    localparam logic [2:0] P_MSG    = 3'd4;
    localparam logic [2:0] P_STATUS = 3'd5;

    // error codes
    localparam logic [2:0] E_NONE  = 3'd0;
    localparam logic [2:0] E_DIGIT = 3'd1;
    localparam logic [2:0] E_PACK  = 3'd2;
    localparam logic [2:0] E_SHORT = 3'd3;
    localparam logic [2:0] E_EMPTY = 3'd4;
    localparam logic [2:0] E_BODY  = 3'd5;
    localparam logic [2:0] E_CAPS  = 3'd6;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [1:0] {
        CMD_BODY,
        CMD_FLUSH,
        CMD_ERROR
    } cmd_type_t;

    typedef struct packed {
        cmd_type_t  ctype;
        logic [3:0] kind;
        logic [7:0] data;
        logic [2:0] code;
        logic       first;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [2:0] part;
        logic [7:0] data;
        logic [3:0] nib;
        logic [1:0] ack;
        logic       unp;
        logic [2:0] err;
        logic       last;
    } result_t;

    localparam logic [3:0] PAT_KIND [NPAT] = '{
        K_DATA, K_PROGRESS, K_SBERR, K_ACK, K_NAK, K_ERR,
        K_COMMENT, K_OK, K_NG, K_UNPACK, K_SHALLOW, K_UNSHALLOW
    };

    localparam logic [3:0] PAT_LEN [NPAT] = '{
        4'd1, 4'd1, 4'd1, 4'd3, 4'd3, 4'd3, 4'd1, 4'd2, 4'd2, 4'd6, 4'd7, 4'd9
    };

    localparam logic [7:0] PAT_TEXT [NPAT][PAT_MAX] = '{
        '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"A", "C", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"N", "A", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"E", "R", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"#", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"o", "k", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"n", "g", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"u", "n", "p", "a", "c", "k", 8'h00, 8'h00, 8'h00},
        '{"s", "h", "a", "l", "l", "o", "w", 8'h00, 8'h00},
        '{"u", "n", "s", "h", "a", "l", "l", "o", "w"}
    };

    localparam logic [7:0] STATUS_TEXT [3][8] = '{
        '{"c", "o", "n", "t", "i", "n", "u", "e"},
        '{"c", "o", "m", "m", "o", "n", 8'h00, 8'h00},
        '{"r", "e", "a", "d", "y", 8'h00, 8'h00, 8'h00}
    };

    localparam logic [7:0] STATUS_LEN [3] = '{8'd8, 8'd6, 8'd5};

    localparam logic [7:0] OK_TAIL [3] = '{" ", "o", "k"};

    // {valid, value} of an ASCII hex digit
    function automatic logic [4:0] hex_dec(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= "0" && b <= "9")
            r = {1'b1, 4'(b - "0")};
        else if (b >= "a" && b <= "f")
            r = {1'b1, 4'(b - "a" + 8'd10)};
        else if (b >= "A" && b <= "F")
            r = {1'b1, 4'(b - "A" + 8'd10)};
        return r;
    endfunction

endpackage

// ===== rtl/pld_front.sv =====
// Front end: length decode, lead-byte buffering, classification and replay.
// Depends on pld_pkg; feeds commands into pld_queue.
module pld_front
    import pld_pkg::*;
#(
    parameter int LEAD_DEPTH = LEAD_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_full
);

    localparam int LCW = $clog2(LEAD_DEPTH + 1);
    localparam int LIW = $clog2(LEAD_DEPTH);

    typedef enum logic [3:0] {
        F_LEN    = 4'b0001,
        F_LEAD   = 4'b0010,
        F_REPLAY = 4'b0100,
        F_MAIN   = 4'b1000
    } fstate_t;

    fstate_t          state_reg, state_next;
    logic [7:0]       lead_reg [LEAD_DEPTH];
    logic [7:0]       lead_nb [LEAD_DEPTH];
    logic [LCW-1:0]   lead_cnt_reg, lead_cnt_next;
    logic [7:0]       len_b_reg [3];
    logic [1:0]       len_cnt_reg, len_cnt_next;
    logic [15:0]      bytes_left_reg, bytes_left_next;
    logic [3:0]       kind_reg, kind_next;
    logic [LIW-1:0]   rp_idx_reg, rp_idx_next;
    logic [LCW-1:0]   rp_n_reg, rp_n_next;

    logic             accept;
    logic [4:0]       h0, h1, h2, h3;
    logic             all_ok, is_pack;
    logic [15:0]      len;
    logic [4:0]       n5;
    logic             complete;
    logic [NPAT-1:0]  pat_bad;
    logic [3:0]       kind_sel;
    logic             done;
    logic             rp_end;

    assign in_ready = (state_reg != F_REPLAY) && !cmd_full;
    assign accept   = in_valid && in_ready;

    assign h0 = hex_dec(len_b_reg[0]);
    assign h1 = hex_dec(len_b_reg[1]);
    assign h2 = hex_dec(len_b_reg[2]);
    assign h3 = hex_dec(in_byte);
    assign all_ok  = h0[4] && h1[4] && h2[4] && h3[4];
    assign is_pack = (len_b_reg[0] == "P") && (len_b_reg[1] == "A") &&
                     (len_b_reg[2] == "C") && (in_byte == "K");
    assign len = {h0[3:0], h1[3:0], h2[3:0], h3[3:0]};

    // lead buffer as it stands with the incoming byte written
    always_comb
    begin
        for (int i = 0; i < LEAD_DEPTH; i++)
        begin
            lead_nb[i] = (LCW'(i) == lead_cnt_reg) ? in_byte : lead_reg[i];
        end
    end

    assign n5       = 5'(lead_cnt_reg) + 5'd1;
    assign complete = (bytes_left_reg == 16'd1);

    always_comb
    begin
        for (int t = 0; t < NPAT; t++)
        begin
            pat_bad[t] = 1'b0;
            for (int i = 0; i < PAT_MAX; i++)
            begin
                if ((5'(i) < n5) && (4'(i) < PAT_LEN[t]) &&
                    (lead_nb[i] != PAT_TEXT[t][i]))
                    pat_bad[t] = 1'b1;
            end
        end
    end

    // first prefix match decides; an unfinished match waits for more bytes
    always_comb
    begin
        kind_sel = K_REF;
        done     = 1'b0;
        for (int t = 0; t < NPAT; t++)
        begin
            if (!done && !pat_bad[t])
            begin
                if (n5 >= 5'(PAT_LEN[t]))
                begin
                    kind_sel = PAT_KIND[t];
                    done     = 1'b1;
                end
                else if (!complete)
                begin
                    kind_sel = K_FLUSH;
                    done     = 1'b1;
                end
            end
        end
    end

    assign rp_end = (LCW'(rp_idx_reg) + LCW'(1)) == rp_n_reg;

    always_comb
    begin
        state_next      = state_reg;
        lead_cnt_next   = lead_cnt_reg;
        len_cnt_next    = len_cnt_reg;
        bytes_left_next = bytes_left_reg;
        kind_next       = kind_reg;
        rp_idx_next     = rp_idx_reg;
        rp_n_next       = rp_n_reg;
        cmd_valid       = 1'b0;
        cmd             = '0;
        cmd.ctype       = CMD_BODY;
        unique case (state_reg)
            F_LEN:
            begin
                if (accept)
                begin
                    if (len_cnt_reg != 2'd3)
                    begin
                        len_cnt_next = len_cnt_reg + 2'd1;
                    end
                    else
                    begin
                        len_cnt_next = 2'd0;
                        cmd_valid    = 1'b1;
                        if (!all_ok)
                        begin
                            cmd.ctype = CMD_ERROR;
                            cmd.code  = is_pack ? E_PACK : E_DIGIT;
                        end
                        else if (len == 16'd0)
                        begin
                            cmd.ctype = CMD_FLUSH;
                        end
                        else if (len < 16'd4)
                        begin
                            cmd.ctype = CMD_ERROR;
                            cmd.code  = E_SHORT;
                        end
                        else if (len == 16'd4)
                        begin
                            cmd.ctype = CMD_ERROR;
                            cmd.code  = E_EMPTY;
                        end
                        else
                        begin
                            cmd_valid       = 1'b0;
                            bytes_left_next = len - 16'd4;
                            lead_cnt_next   = '0;
                            state_next      = F_LEAD;
                        end
                    end
                end
            end
            F_LEAD:
            begin
                if (accept)
                begin
                    bytes_left_next = bytes_left_reg - 16'd1;
                    if (kind_sel == K_FLUSH && n5 < 5'(LEAD_DEPTH))
                    begin
                        lead_cnt_next = lead_cnt_reg + LCW'(1);
                    end
                    else
                    begin
                        kind_next     = (kind_sel == K_FLUSH) ? K_REF : kind_sel;
                        rp_n_next     = lead_cnt_reg + LCW'(1);
                        rp_idx_next   = '0;
                        lead_cnt_next = '0;
                        state_next    = F_REPLAY;
                    end
                end
            end
            F_REPLAY:
            begin
                if (!cmd_full)
                begin
                    cmd_valid = 1'b1;
                    cmd.kind  = kind_reg;
                    cmd.data  = lead_reg[rp_idx_reg];
                    cmd.first = (rp_idx_reg == '0);
                    cmd.last  = rp_end && (bytes_left_reg == 16'd0);
                    if (rp_end)
                        state_next = (bytes_left_reg == 16'd0) ? F_LEN : F_MAIN;
                    else
                        rp_idx_next = rp_idx_reg + LIW'(1);
                end
            end
            F_MAIN:
            begin
                if (accept)
                begin
                    bytes_left_next = bytes_left_reg - 16'd1;
                    cmd_valid       = 1'b1;
                    cmd.kind        = kind_reg;
                    cmd.data        = in_byte;
                    cmd.last        = complete;
                    if (complete)
                        state_next = F_LEN;
                end
            end
            default:
            begin
                state_next = F_LEN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_LEN;
            lead_cnt_reg   <= '0;
            len_cnt_reg    <= 2'd0;
            bytes_left_reg <= 16'd0;
            kind_reg       <= K_FLUSH;
            rp_idx_reg     <= '0;
            rp_n_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            lead_cnt_reg   <= lead_cnt_next;
            len_cnt_reg    <= len_cnt_next;
            bytes_left_reg <= bytes_left_next;
            kind_reg       <= kind_next;
            rp_idx_reg     <= rp_idx_next;
            rp_n_reg       <= rp_n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && state_reg == F_LEN && len_cnt_reg != 2'd3)
            len_b_reg[len_cnt_reg] <= in_byte;
        if (accept && state_reg == F_LEAD)
            lead_reg[lead_cnt_reg[LIW-1:0]] <= in_byte;
    end

endmodule

// ===== rtl/pld_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on pld_pkg for the command type and depth.
module pld_queue
    import pld_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic head_valid,
    output cmd_t head,
    input  logic pop
);

    localparam int PW = $clog2(CMD_DEPTH);
    localparam int CW = $clog2(CMD_DEPTH + 1);

    cmd_t           mem [CMD_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign full       = (cnt_reg == CW'(CMD_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + CW'(1);
        else if (!push && pop)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/pld_back.sv =====
// Back end: per-kind body rules, result generation and the result buffer.
// Depends on pld_pkg; takes commands from pld_queue.
module pld_back
    import pld_pkg::*;
#(
    parameter int MAX_OID_DIGITS = MAX_OID_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    res
);

    localparam int PW = $clog2(RES_DEPTH);
    localparam int CW = $clog2(RES_DEPTH + 1);

    typedef enum logic [2:0] {
        B_MAIN   = 3'b001,
        B_SECOND = 3'b010,
        B_REST   = 3'b100
    } bphase_t;

    logic [6:0]    oid_cfg_reg;
    logic [6:0]    dd;
    bphase_t       ph_reg, ph_c, ph_n;
    logic [4:0]    acc_reg, acc_c, acc_n;
    logic [6:0]    fpos_reg, p;
    logic          caps_reg, caps_n;
    logic          halted_reg;

    result_t       res_mem [RES_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    logic [7:0]    b, p8, d8, q8, ll;
    logic [4:0]    hx;
    logic [2:0]    alive;
    logic          fail;
    logic [2:0]    fcode;
    logic          r0v;
    logic [2:0]    r0p;
    logic [3:0]    r0nib;
    logic [2:0]    tpart;
    logic [1:0]    ackv;
    logic          unpv;
    logic          r1v;
    result_t       r0, r1;
    logic          act, halt_now;
    logic [1:0]    npush;
    logic          out_pop;

    always_comb
    begin
        if (oid_cfg_reg < 7'(OID_MIN))
            dd = 7'(OID_MIN);
        else if (oid_cfg_reg > 7'(MAX_OID_DIGITS))
            dd = 7'(MAX_OID_DIGITS);
        else
            dd = oid_cfg_reg;
    end

    assign b     = cmd.data;
    assign p     = cmd.first ? 7'd0 : fpos_reg;
    assign ph_c  = cmd.first ? B_MAIN : ph_reg;
    assign acc_c = cmd.first ? ((cmd.kind == K_UNPACK) ? 5'd1 : 5'd0) : acc_reg;
    assign p8    = {1'b0, p};
    assign d8    = {1'b0, dd};
    assign q8    = p8 - 8'd5 - d8;
    assign hx    = hex_dec(b);
    assign ll    = (cmd.kind == K_SHALLOW) ? 8'd8 : 8'd10;

    always_comb
    begin
        ph_n   = ph_c;
        acc_n  = acc_c;
        caps_n = caps_reg;
        fail   = 1'b0;
        fcode  = E_BODY;
        r0v    = 1'b0;
        r0p    = P_MSG;
        r0nib  = 4'd0;
        tpart  = P_EVENT;
        ackv   = 2'd0;
        unpv   = 1'b0;
        alive  = acc_c[2:0];
        unique case (cmd.kind)
            K_DATA, K_PROGRESS, K_SBERR:
            begin
                r0v = (p8 != 8'd0);
            end
            K_ACK:
            begin
                if (p8 == 8'd3 && b != CH_SPACE)
                    fail = 1'b1;
                else if (p8 >= 8'd4 && p8 < 8'd4 + d8)
                begin
                    if (hx[4])
                    begin
                        r0v   = 1'b1;
                        r0p   = P_OID;
                        r0nib = hx[3:0];
                    end
                    else
                        fail = 1'b1;
                end
                else if (p8 == 8'd4 + d8)
                begin
                    if (b == CH_SPACE)
                    begin
                        ph_n  = B_SECOND;
                        acc_n = 5'd7;
                    end
                    else
                        ph_n = B_REST;
                end
                else if (p8 > 8'd4 + d8 && ph_c == B_SECOND)
                begin
                    // drop status words that no longer match
                    for (int w = 0; w < 3; w++)
                    begin
                        if (alive[w] && (q8 >= STATUS_LEN[w] ||
                            b != STATUS_TEXT[w][q8[2:0]]))
                            alive[w] = 1'b0;
                    end
                    if (alive == 3'd0)
                        fail = 1'b1;
                    else
                    begin
                        acc_n = {2'd0, alive};
                        for (int w = 0; w < 3; w++)
                        begin
                            if (alive[w] && (q8 + 8'd1 == STATUS_LEN[w]))
                            begin
                                acc_n = {2'(w + 1), 3'd0};
                                ph_n  = B_REST;
                            end
                        end
                    end
                end
                if (!fail && cmd.last)
                begin
                    if (p8 < 8'd3 + d8 || ph_n == B_SECOND)
                        fail = 1'b1;
                    else
                    begin
                        ackv  = acc_n[4:3];
                        tpart = P_STATUS;
                    end
                end
            end
            K_NAK:
            begin
                r0v = 1'b0;
            end
            K_ERR:
            begin
                if (p8 == 8'd3 && b != CH_SPACE)
                    fail = 1'b1;
                else if (p8 >= 8'd4)
                    r0v = 1'b1;
                if (!fail && cmd.last && p8 < 8'd3)
                    fail = 1'b1;
            end
            K_COMMENT:
            begin
                r0v = 1'b1;
            end
            K_OK:
            begin
                if (p8 == 8'd2 && b != CH_SPACE)
                    fail = 1'b1;
                else if (p8 >= 8'd3 && !(cmd.last && b == CH_NL))
                begin
                    r0v = 1'b1;
                    r0p = P_NAME;
                end
                if (!fail && cmd.last && p8 < 8'd2)
                    fail = 1'b1;
            end
            K_NG:
            begin
                if (p8 == 8'd2 && b != CH_SPACE)
                    fail = 1'b1;
                else if (p8 >= 8'd3)
                begin
                    if (ph_c == B_MAIN)
                    begin
                        if (b == CH_SPACE)
                            ph_n = B_SECOND;
                        else
                        begin
                            r0v = 1'b1;
                            r0p = P_NAME;
                        end
                    end
                    else if (ph_c == B_SECOND)
                    begin
                        if (b == CH_NL)
                            ph_n = B_REST;
                        else
                            r0v = 1'b1;
                    end
                end
                if (!fail && cmd.last && ph_n != B_REST)
                    fail = 1'b1;
            end
            K_UNPACK:
            begin
                if (p8 >= 8'd6 && p8 <= 8'd8 && b != OK_TAIL[2'(p8 - 8'd6)])
                    acc_n = 5'd0;
                if (cmd.last)
                begin
                    unpv  = acc_n[0] && (p8 >= 8'd8);
                    tpart = P_STATUS;
                end
            end
            K_SHALLOW, K_UNSHALLOW:
            begin
                if (p8 == ll - 8'd1 && b != CH_SPACE)
                    fail = 1'b1;
                else if (p8 >= ll + d8)
                    fail = 1'b1;
                else if (p8 >= ll)
                begin
                    if (hx[4])
                    begin
                        r0v   = 1'b1;
                        r0p   = P_OID;
                        r0nib = hx[3:0];
                    end
                    else
                        fail = 1'b1;
                end
                if (!fail && cmd.last && (p8 + 8'd1 < ll + d8))
                    fail = 1'b1;
            end
            default:
            begin
                if (p8 < d8)
                begin
                    if (hx[4])
                    begin
                        r0v   = 1'b1;
                        r0p   = P_OID;
                        r0nib = hx[3:0];
                    end
                    else
                        fail = 1'b1;
                end
                else if (p8 == d8)
                begin
                    if (b != CH_SPACE)
                        fail = 1'b1;
                end
                else if (!(cmd.last && b == CH_NL))
                begin
                    if (ph_c == B_MAIN)
                    begin
                        if (b == CH_NUL)
                        begin
                            if (caps_reg)
                            begin
                                fail  = 1'b1;
                                fcode = E_CAPS;
                            end
                            else
                                ph_n = B_SECOND;
                        end
                        else
                        begin
                            r0v = 1'b1;
                            r0p = P_NAME;
                        end
                    end
                    else
                    begin
                        r0v = 1'b1;
                        r0p = P_CAPS;
                    end
                end
                if (!fail && cmd.last)
                begin
                    if (p8 < d8 + 8'd1)
                        fail = 1'b1;
                    else
                        caps_n = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        r0      = '0;
        r0.kind = cmd.kind;
        r0.part = r0p;
        r0.data = b;
        r0.nib  = r0nib;
        r1      = '0;
        r1.last = 1'b1;
        r1v     = 1'b0;
        halt_now = 1'b0;
        unique case (cmd.ctype)
            CMD_BODY:
            begin
                r1v     = fail || cmd.last;
                r1.kind = cmd.kind;
                halt_now = fail;
                if (fail)
                    r1.err = fcode;
                else
                begin
                    r1.part = tpart;
                    r1.ack  = ackv;
                    r1.unp  = unpv;
                end
            end
            CMD_FLUSH:
            begin
                r1v = 1'b1;
            end
            CMD_ERROR:
            begin
                r1v      = 1'b1;
                r1.err   = cmd.code;
                halt_now = 1'b1;
            end
            default:
            begin
                r1v = 1'b0;
            end
        endcase
    end

    // need room for two results before taking a command, unless halted
    assign cmd_pop   = cmd_valid && (halted_reg || cnt_reg <= CW'(RES_DEPTH - 2));
    assign act       = cmd_pop && !halted_reg;
    assign npush     = act ? ({1'b0, (cmd.ctype == CMD_BODY) && r0v} + {1'b0, r1v}) : 2'd0;
    assign out_valid = (cnt_reg != '0);
    assign res       = res_mem[rd_ptr_reg];
    assign out_pop   = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oid_cfg_reg <= 7'd64;
            ph_reg      <= B_MAIN;
            acc_reg     <= 5'd0;
            fpos_reg    <= 7'd0;
            caps_reg    <= 1'b0;
            halted_reg  <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                oid_cfg_reg <= cfg_wr_data;
            if (act && cmd.ctype == CMD_BODY)
            begin
                ph_reg   <= ph_n;
                acc_reg  <= acc_n;
                fpos_reg <= (p < 7'd127) ? p + 7'd1 : p;
                caps_reg <= fail ? caps_reg : caps_n;
            end
            if (act && halt_now)
                halted_reg <= 1'b1;
            wr_ptr_reg <= wr_ptr_reg + PW'(npush);
            if (out_pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            cnt_reg <= cnt_reg + CW'(npush) - CW'(out_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (npush == 2'd2)
        begin
            res_mem[wr_ptr_reg]          <= r0;
            res_mem[wr_ptr_reg + PW'(1)] <= r1;
        end
        else if (npush == 2'd1)
            res_mem[wr_ptr_reg] <= r1v ? r1 : r0;
    end

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    a_no_result_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> npush == 2'd0)
        else $error("result produced while halted");

    a_buffer_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(RES_DEPTH))
        else $error("result buffer overflow");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (act && cmd.ctype == CMD_ERROR) |=> halted_reg)
        else $error("length error did not halt");

endmodule

// ===== rtl/pkt_line_stream_decoder.sv =====
// Top level of the pkt-line stream decoder: front end, command queue, back end.
// Depends on pld_pkg, pld_front, pld_queue and pld_back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | in_valid / in_ready    | in_byte
//  result   | out_valid / out_ready  | pkt_kind part out_byte oid_nibble
//           |                        | ack_status unpack_good error_code last
//  config   | cfg_wr_en              | cfg_wr_data (oid_hex_digits)
//
// One byte per cycle in the length digits and the packet body while the command
// queue is not full; once a packet's class is known the front end replays its
// buffered lead bytes, one per cycle unless the queue is full, holding in_ready
// low while up to LEAD_DEPTH bytes are replayed. The back end emits up to two
// results per command into a four-entry result buffer, through the registered queue.
// rst_n clears all control state asynchronously; no clearing pass is needed.
module pkt_line_stream_decoder
    import pld_pkg::*;
#(
    parameter int LEAD_DEPTH     = LEAD_DEPTH_DEF,
    parameter int MAX_OID_DIGITS = MAX_OID_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] pkt_kind,
    output logic [2:0] part,
    output logic [7:0] out_byte,
    output logic [3:0] oid_nibble,
    output logic [1:0] ack_status,
    output logic       unpack_good,
    output logic [2:0] error_code,
    output logic       last
);

    logic    f_valid, q_full, q_valid, q_pop;
    cmd_t    f_cmd, q_head;
    result_t res;

    pld_front #(.LEAD_DEPTH(LEAD_DEPTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .cmd_valid (f_valid),
        .cmd       (f_cmd),
        .cmd_full  (q_full)
    );

    pld_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_valid),
        .push_cmd   (f_cmd),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop)
    );

    pld_back #(.MAX_OID_DIGITS(MAX_OID_DIGITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (q_valid),
        .cmd         (q_head),
        .cmd_pop     (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .res         (res)
    );

    assign pkt_kind    = res.kind;
    assign part        = res.part;
    assign out_byte    = res.data;
    assign oid_nibble  = res.nib;
    assign ack_status  = res.ack;
    assign unpack_good = res.unp;
    assign error_code  = res.err;
    assign last        = res.last;

endmodule

// ===== tb/pkt_line_stream_decoder_tb.sv =====
// Self-checking testbench for pkt_line_stream_decoder: a scoreboard class predicts
// every result from the accepted byte stream; tasks drive bytes, config and stalls.
// Depends on pld_pkg and the decoder RTL.
module pkt_line_stream_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pld_pkg::*;

    typedef bit [7:0] byte_q_t[$];
    typedef enum int {S_LEN, S_LEAD, S_MAIN, S_SECOND, S_REST} rx_phase_t;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int LONG_HOLD       = 300;
    localparam int RANDOM_BYTES    = 200;

    class pkt_scoreboard;
        result_t    exp_q[$];
        int         errors;
        bit [6:0]   oid_cfg;
        rx_phase_t  ph;
        bit [15:0]  acc;
        bit [15:0]  left;
        bit [7:0]   lead[LEAD_DEPTH_DEF];
        int         lead_n;
        bit [3:0]   kind;
        bit [6:0]   fpos;
        bit         caps;
        bit         halted;

        function new();
            errors = 0;
            oid_cfg = 7'd64;
            ph = S_LEN;
            acc = 0;
            left = 0;
            lead_n = 0;
            kind = K_FLUSH;
            fpos = 0;
            caps = 0;
            halted = 0;
        endfunction

        function int pending();
            return exp_q.size();
        endfunction

        function void set_oid(bit [6:0] v);
            oid_cfg = v;
        endfunction

        function int digits();
            if (oid_cfg < OID_MIN)
                return OID_MIN;
            if (oid_cfg > MAX_OID_DEF)
                return MAX_OID_DEF;
            return int'(oid_cfg);
        endfunction

        function int hexv(bit [7:0] b);
            if (b >= "0" && b <= "9")
                return int'(b) - int'("0");
            if (b >= "a" && b <= "f")
                return int'(b) - int'("a") + 10;
            if (b >= "A" && b <= "F")
                return int'(b) - int'("A") + 10;
            return -1;
        endfunction

        function void push(bit [3:0] k, bit [2:0] pt, bit [7:0] b, bit [3:0] nb,
                           bit [1:0] ak, bit up, bit [2:0] er, bit ls);
            result_t r;
            r.kind = k;
            r.part = pt;
            r.data = b;
            r.nib = nb;
            r.ack = ak;
            r.unp = up;
            r.err = er;
            r.last = ls;
            exp_q.push_back(r);
        endfunction

        function bit fail(bit [2:0] code);
            push(kind, P_EVENT, 0, 0, 0, 0, code, 1);
            halted = 1;
            return 0;
        endfunction

        function bit oid_digit(bit [3:0] k, bit [7:0] b);
            int h;
            h = hexv(b);
            if (h < 0)
                return fail(E_BODY);
            push(k, P_OID, b, h[3:0], 0, 0, E_NONE, 0);
            return 1;
        endfunction

        function bit [3:0] classify(int n, bit complete);
            int len;
            int m;
            bit bad;
            for (int t = 0; t < NPAT; t++)
            begin
                len = PAT_LEN[t];
                m = (n < len) ? n : len;
                bad = 0;
                for (int i = 0; i < m; i++)
                    if (lead[i] != PAT_TEXT[t][i])
                        bad = 1;
                if (bad)
                    continue;
                if (n >= len)
                    return PAT_KIND[t];
                if (!complete)
                    return K_FLUSH;
            end
            return K_REF;
        endfunction

        function bit body_byte(bit [7:0] b, bit lst);
            int p;
            int d;
            int q;
            int lim;
            bit [3:0] k;
            bit [1:0] ak;
            bit up;
            bit [2:0] tpart;
            bit [2:0] alive;
            p = fpos;
            d = digits();
            k = kind;
            ak = 0;
            up = 0;
            tpart = P_EVENT;
            if (fpos < 127)
                fpos++;
            case (k)
                K_DATA, K_PROGRESS, K_SBERR:
                    if (p > 0)
                        push(k, P_MSG, b, 0, 0, 0, E_NONE, 0);
                K_ACK:
                begin
                    if (p == 3 && b != CH_SPACE)
                        return fail(E_BODY);
                    if (p >= 4 && p < 4 + d)
                    begin
                        if (!oid_digit(k, b))
                            return 0;
                    end
                    else if (p == 4 + d)
                    begin
                        if (b == CH_SPACE)
                        begin
                            ph = S_SECOND;
                            acc = 7;
                        end
                        else
                            ph = S_REST;
                    end
                    else if (p > 4 + d && ph == S_SECOND)
                    begin
                        // narrow the set of status words still matching
                        q = p - 5 - d;
                        alive = acc[2:0];
                        for (int w = 0; w < 3; w++)
                            if (alive[w] && (q >= STATUS_LEN[w] || b != STATUS_TEXT[w][q]))
                                alive[w] = 0;
                        if (alive == 0)
                            return fail(E_BODY);
                        acc = 16'(alive);
                        for (int w = 0; w < 3; w++)
                            if (alive[w] && q + 1 == STATUS_LEN[w])
                            begin
                                acc = 16'((w + 1) << 3);
                                ph = S_REST;
                            end
                    end
                    if (lst)
                    begin
                        if (p < 3 + d || ph == S_SECOND)
                            return fail(E_BODY);
                        ak = acc[4:3];
                        tpart = P_STATUS;
                    end
                end
                K_NAK:
                    ;
                K_ERR:
                begin
                    if (p == 3 && b != CH_SPACE)
                        return fail(E_BODY);
                    if (p >= 4)
                        push(k, P_MSG, b, 0, 0, 0, E_NONE, 0);
                    if (lst && p < 3)
                        return fail(E_BODY);
                end
                K_COMMENT:
                    push(k, P_MSG, b, 0, 0, 0, E_NONE, 0);
                K_OK:
                begin
                    if (p == 2 && b != CH_SPACE)
                        return fail(E_BODY);
                    if (p >= 3 && !(lst && b == CH_NL))
                        push(k, P_NAME, b, 0, 0, 0, E_NONE, 0);
                    if (lst && p < 2)
                        return fail(E_BODY);
                end
                K_NG:
                begin
                    if (p == 2 && b != CH_SPACE)
                        return fail(E_BODY);
                    if (p >= 3)
                    begin
                        if (ph == S_MAIN)
                        begin
                            if (b == CH_SPACE)
                                ph = S_SECOND;
                            else
                                push(k, P_NAME, b, 0, 0, 0, E_NONE, 0);
                        end
                        else if (ph == S_SECOND)
                        begin
                            if (b == CH_NL)
                                ph = S_REST;
                            else
                                push(k, P_MSG, b, 0, 0, 0, E_NONE, 0);
                        end
                    end
                    if (lst && ph != S_REST)
                        return fail(E_BODY);
                end
                K_UNPACK:
                begin
                    if (p >= 6 && p <= 8 && b != OK_TAIL[p - 6])
                        acc = 0;
                    if (lst)
                    begin
                        up = acc[0] && p >= 8;
                        tpart = P_STATUS;
                    end
                end
                K_SHALLOW, K_UNSHALLOW:
                begin
                    lim = (k == K_SHALLOW) ? 8 : 10;
                    if (p == lim - 1 && b != CH_SPACE)
                        return fail(E_BODY);
                    if (p >= lim + d)
                        return fail(E_BODY);
                    if (p >= lim && !oid_digit(k, b))
                        return 0;
                    if (lst && p + 1 < lim + d)
                        return fail(E_BODY);
                end
                default:
                begin
                    if (p < d)
                    begin
                        if (!oid_digit(k, b))
                            return 0;
                    end
                    else if (p == d)
                    begin
                        if (b != CH_SPACE)
                            return fail(E_BODY);
                    end
                    else if (!(lst && b == CH_NL))
                    begin
                        if (ph == S_MAIN)
                        begin
                            if (b == CH_NUL)
                            begin
                                if (caps)
                                    return fail(E_CAPS);
                                ph = S_SECOND;
                            end
                            else
                                push(k, P_NAME, b, 0, 0, 0, E_NONE, 0);
                        end
                        else
                            push(k, P_CAPS, b, 0, 0, 0, E_NONE, 0);
                    end
                    if (lst)
                    begin
                        if (p < d + 1)
                            return fail(E_BODY);
                        caps = 1;
                    end
                end
            endcase
            if (lst)
            begin
                push(k, tpart, 0, 0, ak, up, E_NONE, 1);
                ph = S_LEN;
                lead_n = 0;
                acc = 0;
                fpos = 0;
                kind = K_FLUSH;
            end
            return 1;
        endfunction

        // note one accepted input transfer
        function void note_byte(bit [7:0] b);
            int len;
            int h;
            int n;
            bit [3:0] k;
            bit pack;
            if (halted)
                return;
            if (ph == S_LEN)
            begin
                if (lead_n < LEAD_DEPTH_DEF)
                    lead[lead_n] = b;
                lead_n++;
                if (lead_n < 4)
                    return;
                lead_n = 0;
                kind = K_FLUSH;
                len = 0;
                for (int i = 0; i < 4; i++)
                begin
                    h = hexv(lead[i]);
                    if (h < 0)
                    begin
                        pack = lead[0] == "P" && lead[1] == "A" && lead[2] == "C"
                               && lead[3] == "K";
                        void'(fail(pack ? E_PACK : E_DIGIT));
                        return;
                    end
                    len = (len << 4) | h;
                end
                acc = 16'(len);
                if (len == 0)
                    push(K_FLUSH, P_EVENT, 0, 0, 0, 0, E_NONE, 1);
                else if (len < 4)
                    void'(fail(E_SHORT));
                else if (len == 4)
                    void'(fail(E_EMPTY));
                else
                begin
                    left = 16'(len - 4);
                    ph = S_LEAD;
                end
                return;
            end
            if (left != 0)
                left--;
            if (ph == S_LEAD)
            begin
                if (lead_n < LEAD_DEPTH_DEF)
                begin
                    lead[lead_n] = b;
                    lead_n++;
                end
                k = classify(lead_n, left == 0);
                if (k == K_FLUSH && lead_n < LEAD_DEPTH_DEF)
                    return;
                if (k == K_FLUSH)
                    k = K_REF;
                kind = k;
                ph = S_MAIN;
                fpos = 0;
                acc = (k == K_UNPACK) ? 16'd1 : 16'd0;
                n = lead_n;
                lead_n = 0;
                // release the held lead bytes
                for (int i = 0; i < n; i++)
                    if (!body_byte(lead[i], i + 1 == n && left == 0))
                        break;
                return;
            end
            void'(body_byte(b, left == 0));
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (exp_q.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d part %0d byte %02h err %0d",
                                 got.kind, got.part, got.data, got.err));
                return;
            end
            want = exp_q.pop_front();
            if (got.kind != want.kind || got.part != want.part || got.data != want.data
                || got.nib != want.nib || got.ack != want.ack || got.unp != want.unp
                || got.err != want.err || got.last != want.last)
                report($sformatf({"got k%0d p%0d b%02h n%0h a%0d u%0d e%0d l%0d, ",
                                  "want k%0d p%0d b%02h n%0h a%0d u%0d e%0d l%0d"},
                                 got.kind, got.part, got.data, got.nib, got.ack, got.unp,
                                 got.err, got.last, want.kind, want.part, want.data,
                                 want.nib, want.ack, want.unp, want.err, want.last));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       cfg_wr_en = 1'b0;
    logic [6:0] cfg_wr_data = 7'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [3:0] pkt_kind;
    logic [2:0] part;
    logic [7:0] out_byte;
    logic [3:0] oid_nibble;
    logic [1:0] ack_status;
    logic       unpack_good;
    logic [2:0] error_code;
    logic       last;

    pkt_scoreboard sb = new();

    int  sent_bytes = 0;
    int  gap_mode = 0;
    int  burst_left = 0;
    bit  refs_sent = 0;
    bit  long_hold_req = 0;
    bit  long_hold_done = 0;
    int  hold_left = 0;
    int  rx_cycle = 0;
    int  quiet_cycles = 0;

    pkt_line_stream_decoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pkt_kind    (pkt_kind),
        .part        (part),
        .out_byte    (out_byte),
        .oid_nibble  (oid_nibble),
        .ack_status  (ack_status),
        .unpack_good (unpack_good),
        .error_code  (error_code),
        .last        (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result monitor and watchdog
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.kind = pkt_kind;
            got.part = part;
            got.data = out_byte;
            got.nib = oid_nibble;
            got.ack = ack_status;
            got.unp = unpack_good;
            got.err = error_code;
            got.last = last;
            sb.check_result(got);
        end
        if (!rst_n || (out_valid && out_ready) || (in_valid && in_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_CYCLES)
        begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_CYCLES);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: rotating stall patterns plus one long hold-off
    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            long_hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else
        begin
            case ((rx_cycle >> 9) % 3)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ~rx_cycle[3];
            endcase
        end
    end

    task automatic send_byte(bit [7:0] b);
        int g;
        if (burst_left == 0)
        begin
            case (gap_mode)
                0: begin g = 0; burst_left = 1000; end
                1: begin g = $urandom_range(1, 3); burst_left = $urandom_range(1, 8); end
                default: begin g = $urandom_range(1, 10); burst_left = $urandom_range(10, 30); end
            endcase
            if (g > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b);
        sent_bytes++;
    endtask

    task automatic send_all(byte_q_t q);
        foreach (q[i])
            send_byte(q[i]);
    endtask

    // hold the input idle until every expected result has arrived
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_oid_digits(bit [6:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        sb.set_oid(v);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic bit [7:0] hex_char(int v);
        bit upper;
        upper = $urandom_range(0, 1);
        if (v < 10)
            return 8'("0" + v);
        return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
    endfunction

    function automatic void add_text(ref byte_q_t q, input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endfunction

    function automatic void add_oid(ref byte_q_t q, input int n);
        for (int i = 0; i < n; i++)
            q.push_back(hex_char($urandom_range(0, 15)));
    endfunction

    function automatic void add_chars(ref byte_q_t q, input int n, input int lo, input int hi);
        for (int i = 0; i < n; i++)
            q.push_back(8'($urandom_range(lo, hi)));
    endfunction

    // prepend the four length digits to a payload
    function automatic byte_q_t framed(byte_q_t body);
        byte_q_t q;
        int total;
        total = body.size() + 4;
        for (int i = 3; i >= 0; i--)
            q.push_back(hex_char((total >> (4 * i)) & 15));
        foreach (body[i])
            q.push_back(body[i]);
        return q;
    endfunction

    function automatic byte_q_t good_packet();
        byte_q_t q;
        string words[3];
        int d;
        int v;
        words = '{"continue", "common", "ready"};
        d = sb.digits();
        case ($urandom_range(0, 12))
            0:
            begin
                add_text(q, "0000");
                return q;
            end
            1:
            begin
                q.push_back(8'($urandom_range(1, 3)));
                add_chars(q, $urandom_range(0, 6), 0, 255);
            end
            2:
            begin
                add_text(q, "ACK ");
                add_oid(q, d);
                v = $urandom_range(0, 2);
                if (v == 1)
                begin
                    q.push_back(CH_SPACE);
                    add_text(q, words[$urandom_range(0, 2)]);
                    add_chars(q, $urandom_range(0, 2), 32, 126);
                end
                else if (v == 2)
                begin
                    add_chars(q, 1, 33, 126);
                    add_chars(q, $urandom_range(0, 3), 32, 126);
                end
            end
            3:
            begin
                add_text(q, "NAK");
                add_chars(q, $urandom_range(0, 3), 32, 126);
            end
            4:
            begin
                add_text(q, "ERR ");
                add_chars(q, $urandom_range(0, 5), 0, 255);
            end
            5:
            begin
                add_text(q, "#");
                add_chars(q, $urandom_range(0, 5), 0, 255);
            end
            6:
            begin
                add_text(q, "ok ");
                add_chars(q, $urandom_range(0, 6), 33, 126);
                if ($urandom_range(0, 1))
                    q.push_back(CH_NL);
            end
            7:
            begin
                add_text(q, "ng ");
                add_chars(q, $urandom_range(1, 5), 33, 126);
                q.push_back(CH_SPACE);
                add_chars(q, $urandom_range(0, 5), 32, 126);
                q.push_back(CH_NL);
                add_chars(q, $urandom_range(0, 2), 0, 255);
            end
            8:
            begin
                add_text(q, "unpack");
                if ($urandom_range(0, 1))
                    add_text(q, " ok");
                else
                begin
                    q.push_back(CH_SPACE);
                    add_chars(q, $urandom_range(0, 4), 97, 122);
                end
                if ($urandom_range(0, 1))
                    q.push_back(CH_NL);
            end
            9:
            begin
                add_text(q, "shallow ");
                add_oid(q, d);
            end
            10:
            begin
                add_text(q, "unshallow ");
                add_oid(q, d);
            end
            default:
            begin
                add_oid(q, d);
                q.push_back(CH_SPACE);
                add_chars(q, $urandom_range(1, 6), 33, 126);
                // only the first ref line may carry capabilities
                if (!refs_sent && $urandom_range(0, 1))
                begin
                    q.push_back(CH_NUL);
                    add_chars(q, $urandom_range(0, 5), 0, 255);
                end
                if ($urandom_range(0, 1))
                    q.push_back(CH_NL);
                refs_sent = 1;
            end
        endcase
        return framed(q);
    endfunction

    // one broken packet to end the run; the block halts after it
    function automatic byte_q_t broken_packet();
        byte_q_t q;
        byte_q_t body;
        int d;
        d = sb.digits();
        case ($urandom_range(0, 6))
            0: add_text(q, "00g5");
            1: add_text(q, "PACK");
            2: add_text(q, "0002");
            3: add_text(q, "0004");
            4:
            begin
                add_oid(body, $urandom_range(0, d - 1));
                body.push_back("g");
                add_oid(body, 2);
                q = framed(body);
            end
            5:
            begin
                if (refs_sent)
                begin
                    add_oid(body, d);
                    add_text(body, " name");
                    body.push_back(CH_NUL);
                    add_text(body, "caps");
                end
                else
                begin
                    add_text(body, "ACK ");
                    add_oid(body, d);
                    add_text(body, " comfy");
                end
                q = framed(body);
            end
            default:
            begin
                add_text(body, "ng name msg");
                q = framed(body);
            end
        endcase
        add_chars(q, 8, 0, 255);
        return q;
    endfunction

    initial
    begin
        bit [6:0] oid_settings[6];
        byte_q_t  q;
        int       target;
        oid_settings = '{7'd64, 7'd40, 7'd0, 7'd127, 7'd52, 7'd64};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // flush, sideband extremes, unpack ok
        add_text(q, "0000");
        add_text(q, "0007");
        q.push_back(8'h01);
        q.push_back(8'h00);
        q.push_back(8'hff);
        add_text(q, "000Eunpack ok");
        q.push_back(CH_NL);
        send_all(q);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            write_oid_digits(oid_settings[ph]);
            target = sent_bytes + RANDOM_BYTES / 6;
            // hold off the receiver while this phase keeps sending
            if (ph == 2)
                long_hold_req = 1;
            while (sent_bytes < target)
            begin
                gap_mode = $urandom_range(0, 2);
                burst_left = 0;
                send_all(good_packet());
            end
        end
        drain();
        send_all(broken_packet());
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
